// File: rtl/core/per_context_lowest_free_id_allocator_defines.svh
// ----------------------------------------------------------------------------
// ID allocator assertion macros
// Concurrent assertion shorthands used by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef PER_CONTEXT_LOWEST_FREE_ID_ALLOCATOR_DEFINES_SVH
`define PER_CONTEXT_LOWEST_FREE_ID_ALLOCATOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PID_ALLOC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PID_ALLOC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pid_alloc_pkg.sv
// ----------------------------------------------------------------------------
// ID allocator package
// Beat layout, request and status codes, heap engine command type.
// ----------------------------------------------------------------------------
`default_nettype none

package pid_alloc_pkg;

  // input beat: action, context, freed id (lowest bit up)
  localparam int ACT_W     = 2;
  localparam int CTX_W     = 7;
  localparam int FID_W     = 16;
  localparam int CTX_LSB   = ACT_W;
  localparam int FID_LSB   = ACT_W + CTX_W;
  localparam int S_TDATA_W = 32;

  // output beat: granted id, status
  localparam int GNT_W     = 16;
  localparam int ST_W      = 2;
  localparam int M_TDATA_W = 24;
  localparam int M_PAD_W   = M_TDATA_W - GNT_W - ST_W;

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESET = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_CTX   = 2'd1;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic start;
    logic pop;    // 1: remove minimum, 0: insert
  } eng_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/pid_alloc_ctx_mem.sv
// ----------------------------------------------------------------------------
// ID allocator context memory
// Per-context fresh counter and heap fill count, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_alloc_ctx_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 23
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o,
  output logic               ready_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

`default_nettype wire

// File: rtl/core/pid_alloc_heap_mem.sv
// ----------------------------------------------------------------------------
// ID allocator heap store
// One write port and two registered read ports; rows are {context, slot}.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_alloc_heap_mem #(
  parameter int AW = 12,
  parameter int DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_a_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output logic      [DW-1:0] rdata_a_o,
  output logic      [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_a_q;
  logic [DW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// File: rtl/core/pid_alloc_heap_eng.sv
// ----------------------------------------------------------------------------
// ID allocator heap engine
// Sift-up insert and sift-down minimum removal, read then compare per level.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_alloc_heap_eng #(
  parameter int XW  = 6,
  parameter int AW  = 6,
  parameter int CW  = 7,
  parameter int IDW = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pid_alloc_pkg::eng_cmd_t   cmd_i,
  input  wire logic [XW-1:0]             ctx_i,
  input  wire logic [CW-1:0]             count_i,
  input  wire logic [IDW-1:0]            val_i,
  output logic                           done_o,
  output logic      [IDW-1:0]            top_o
);

  localparam int HW = XW + AW;

  localparam logic [2:0] E_IDLE     = 3'd0;
  localparam logic [2:0] E_PUSH_RD  = 3'd1;
  localparam logic [2:0] E_PUSH_CMP = 3'd2;
  localparam logic [2:0] E_POP_RD0  = 3'd3;
  localparam logic [2:0] E_POP_TOP  = 3'd4;
  localparam logic [2:0] E_POP_RD   = 3'd5;
  localparam logic [2:0] E_POP_CMP  = 3'd6;

  logic [2:0]     state_q, state_d;
  logic [XW-1:0]  ctx_q, ctx_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [AW-1:0]  m_q, m_d;      // entries left after a pop
  logic [AW-1:0]  par_q, par_d;  // parent on insert, left child on removal
  logic [IDW-1:0] val_q, val_d;  // value being placed
  logic [IDW-1:0] top_q, top_d;

  logic           we;
  logic [HW-1:0]  waddr;
  logic [IDW-1:0] wdata;
  logic [HW-1:0]  raddr_a;
  logic [HW-1:0]  raddr_b;
  logic [IDW-1:0] rdata_a;
  logic [IDW-1:0] rdata_b;

  logic [CW-1:0]  cnt_dec;
  logic [AW-1:0]  pidx;
  logic [AW:0]    lc;
  logic [AW:0]    rc;
  logic [AW:0]    rc_cmp;
  logic           rsel;
  logic [IDW-1:0] hc;
  logic [AW-1:0]  cidx;

  pid_alloc_heap_mem #(
    .AW(HW),
    .DW(IDW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign cnt_dec = count_i - 1'b1;
  assign pidx    = (idx_q - 1'b1) >> 1;
  assign lc      = {idx_q, 1'b1};
  assign rc      = lc + 1'b1;
  assign rc_cmp  = {1'b0, par_q} + 1'b1;
  // right child only counts if it lies inside the shrunk heap
  assign rsel    = (rc_cmp < {1'b0, m_q}) && (rdata_b < rdata_a);
  assign hc      = rsel ? rdata_b : rdata_a;
  assign cidx    = rsel ? (par_q + 1'b1) : par_q;

  // No read whose result is used hits the row written in that cycle, so the
  // store needs no bypass.
  always_comb begin
    state_d = state_q;
    ctx_d   = ctx_q;
    idx_d   = idx_q;
    m_d     = m_q;
    par_d   = par_q;
    val_d   = val_q;
    top_d   = top_q;
    we      = 1'b0;
    waddr   = {ctx_q, idx_q};
    wdata   = val_q;
    raddr_a = {ctx_q, {AW{1'b0}}};
    raddr_b = {ctx_q, {AW{1'b0}}};
    done_o  = 1'b0;
    case (state_q)
      E_IDLE: begin
        if (cmd_i.start) begin
          ctx_d = ctx_i;
          val_d = val_i;
          if (cmd_i.pop) begin
            m_d     = cnt_dec[AW-1:0];
            state_d = E_POP_RD0;
          end else begin
            idx_d   = count_i[AW-1:0];
            state_d = E_PUSH_RD;
          end
        end
      end
      E_PUSH_RD: begin
        if (idx_q == '0) begin
          we      = 1'b1;
          done_o  = 1'b1;
          state_d = E_IDLE;
        end else begin
          raddr_a = {ctx_q, pidx};
          par_d   = pidx;
          state_d = E_PUSH_CMP;
        end
      end
      E_PUSH_CMP: begin
        we = 1'b1;
        if (rdata_a <= val_q) begin
          done_o  = 1'b1;
          state_d = E_IDLE;
        end else begin
          wdata   = rdata_a;
          idx_d   = par_q;
          state_d = E_PUSH_RD;
        end
      end
      E_POP_RD0: begin
        raddr_b = {ctx_q, m_q};
        state_d = E_POP_TOP;
      end
      E_POP_TOP: begin
        top_d   = rdata_a;
        val_d   = rdata_b;   // last entry, to be sifted down from the root
        idx_d   = '0;
        state_d = E_POP_RD;
      end
      E_POP_RD: begin
        if (lc >= {1'b0, m_q}) begin
          we      = (m_q != '0);
          done_o  = 1'b1;
          state_d = E_IDLE;
        end else begin
          raddr_a = {ctx_q, lc[AW-1:0]};
          raddr_b = {ctx_q, rc[AW-1:0]};
          par_d   = lc[AW-1:0];
          state_d = E_POP_CMP;
        end
      end
      E_POP_CMP: begin
        we = 1'b1;
        if (hc >= val_q) begin
          done_o  = 1'b1;
          state_d = E_IDLE;
        end else begin
          wdata   = hc;
          idx_d   = cidx;
          state_d = E_POP_RD;
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q <= ctx_d;
    idx_q <= idx_d;
    m_q   <= m_d;
    par_q <= par_d;
    val_q <= val_d;
    top_q <= top_d;
  end

  assign top_o = top_q;

endmodule

`default_nettype wire

// File: rtl/core/per_context_lowest_free_id_allocator.sv
// ----------------------------------------------------------------------------
// Per-context lowest-free ID allocator
// Fresh counters plus a min-heap of returned IDs for every context.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the context memory is swept
// clear, and no request beat is taken until the sweep is done. A request on a
// bad context, an undefined action, a fresh allocate, a reset, an exhausted
// allocate or a free to a full heap goes from accept through the context read
// state and the output state into the result register. A free sifts up and an
// allocate from the heap sifts down, with a read state and a compare state per
// heap level, since the heap store's reads are registered. A finished result
// waits in the output register while the next request is accepted.
`default_nettype none

module per_context_lowest_free_id_allocator #(
  parameter int CONTEXTS   = 64,
  parameter int HEAP_DEPTH = 64,
  parameter int ID_BITS    = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // action [1:0], context_req [8:2], freed_id [24:9], zero fill
  input  wire logic [pid_alloc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // granted_id [15:0], status [17:16], zero fill
  output logic      [pid_alloc_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  localparam int XW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int DW = ID_BITS + CW;
  localparam int CTX_W = pid_alloc_pkg::CTX_W;
  localparam int GNT_W = pid_alloc_pkg::GNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CTX  = 2'd1;
  localparam logic [1:0] S_HEAP = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                          state_q, state_d;
  logic [pid_alloc_pkg::ACT_W-1:0]     act_q, act_d;
  logic [CTX_W-1:0]                    ctx_q, ctx_d;
  logic [ID_BITS-1:0]                  fid_q, fid_d;
  logic [ID_BITS-1:0]                  gnt_q, gnt_d;
  logic [pid_alloc_pkg::ST_W-1:0]      st_q, st_d;
  logic                                m_valid_q, m_valid_d;
  logic [pid_alloc_pkg::M_TDATA_W-1:0] m_data_q, m_data_d;

  logic [pid_alloc_pkg::ACT_W-1:0] in_act;
  logic [CTX_W-1:0]                in_ctx;
  logic [pid_alloc_pkg::FID_W-1:0] in_fid;
  logic [ID_BITS+15:0]             fid_ext;
  logic [GNT_W+ID_BITS-1:0]        gnt_ext;
  logic [XW+CTX_W-1:0]             in_ctx_ext;
  logic [XW+CTX_W-1:0]             ctx_ext;
  logic                            in_fire;
  logic                            ctx_ok;

  logic               ctx_ready;
  logic               ctx_we;
  logic [DW-1:0]      ctx_wdata;
  logic [DW-1:0]      ctx_rdata;
  logic [CW-1:0]      cnt;
  logic [ID_BITS-1:0] ctr;
  logic [CW-1:0]      cnt_inc;
  logic [CW-1:0]      cnt_dec;
  logic [ID_BITS-1:0] ctr_inc;

  pid_alloc_pkg::eng_cmd_t eng_cmd;
  logic                    eng_done;
  logic [ID_BITS-1:0]      eng_top;

  assign in_act     = s_axis_tdata[0 +: pid_alloc_pkg::ACT_W];
  assign in_ctx     = s_axis_tdata[pid_alloc_pkg::CTX_LSB +: CTX_W];
  assign in_fid     = s_axis_tdata[pid_alloc_pkg::FID_LSB +: pid_alloc_pkg::FID_W];
  assign fid_ext    = {{ID_BITS{1'b0}}, in_fid};
  assign in_ctx_ext = {{XW{1'b0}}, in_ctx};
  assign ctx_ext    = {{XW{1'b0}}, ctx_q};
  assign gnt_ext    = {{GNT_W{1'b0}}, gnt_q};

  assign s_axis_tready = (state_q == S_IDLE) && ctx_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign ctx_ok        = ({25'd0, ctx_q} < 32'(CONTEXTS));

  assign cnt     = ctx_rdata[CW-1:0];
  assign ctr     = ctx_rdata[DW-1:CW];
  assign cnt_inc = cnt + 1'b1;
  assign cnt_dec = cnt - 1'b1;
  assign ctr_inc = ctr + 1'b1;

  pid_alloc_ctx_mem #(
    .DEPTH(CONTEXTS),
    .AW   (XW),
    .DW   (DW)
  ) u_ctx_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (ctx_we),
    .waddr_i(ctx_ext[XW-1:0]),
    .wdata_i(ctx_wdata),
    .raddr_i(in_ctx_ext[XW-1:0]),
    .rdata_o(ctx_rdata),
    .ready_o(ctx_ready)
  );

  pid_alloc_heap_eng #(
    .XW (XW),
    .AW (AW),
    .CW (CW),
    .IDW(ID_BITS)
  ) u_heap_eng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (eng_cmd),
    .ctx_i  (ctx_ext[XW-1:0]),
    .count_i(cnt),
    .val_i  (fid_q),
    .done_o (eng_done),
    .top_o  (eng_top)
  );

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    ctx_d     = ctx_q;
    fid_d     = fid_q;
    gnt_d     = gnt_q;
    st_d      = st_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    ctx_we    = 1'b0;
    ctx_wdata = {ctr, cnt};
    eng_cmd   = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          act_d   = in_act;
          ctx_d   = in_ctx;
          fid_d   = fid_ext[ID_BITS-1:0];
          state_d = S_CTX;
        end
      end
      S_CTX: begin
        gnt_d   = '0;
        st_d    = pid_alloc_pkg::ST_OK;
        state_d = S_OUT;
        if (!ctx_ok) begin
          st_d = pid_alloc_pkg::ST_BAD_CTX;
        end else begin
          case (act_q)
            pid_alloc_pkg::ACT_ALLOC: begin
              if (cnt != '0) begin
                eng_cmd.start = 1'b1;
                eng_cmd.pop   = 1'b1;
                ctx_we        = 1'b1;
                ctx_wdata     = {ctr, cnt_dec};
                state_d       = S_HEAP;
              end else if (ctr == '1) begin
                st_d = pid_alloc_pkg::ST_EXHAUSTED;
              end else begin
                ctx_we    = 1'b1;
                ctx_wdata = {ctr_inc, cnt};
                gnt_d     = ctr_inc;
              end
            end
            pid_alloc_pkg::ACT_FREE: begin
              if (cnt == CW'(HEAP_DEPTH)) begin
                st_d = pid_alloc_pkg::ST_FULL;
              end else begin
                eng_cmd.start = 1'b1;
                ctx_we        = 1'b1;
                ctx_wdata     = {ctr, cnt_inc};
                state_d       = S_HEAP;
              end
            end
            pid_alloc_pkg::ACT_RESET: begin
              ctx_we    = 1'b1;
              ctx_wdata = '0;
            end
            default: begin
              // undefined action: no effect
            end
          endcase
        end
      end
      S_HEAP: begin
        if (eng_done) begin
          if (act_q == pid_alloc_pkg::ACT_ALLOC) begin
            gnt_d = eng_top;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {{pid_alloc_pkg::M_PAD_W{1'b0}}, st_q, gnt_ext[GNT_W-1:0]};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    ctx_q    <= ctx_d;
    fid_q    <= fid_d;
    gnt_q    <= gnt_d;
    st_q     <= st_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// File: rtl/core/pid_alloc_chk.sv
// ----------------------------------------------------------------------------
// ID allocator port checker
// Assertions on the allocator's stream ports, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_context_lowest_free_id_allocator_defines.svh"

module pid_alloc_chk (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [pid_alloc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [pid_alloc_pkg::GNT_W-1:0] grant;
  logic [pid_alloc_pkg::ST_W-1:0]  status;

  assign grant  = m_axis_tdata[0 +: pid_alloc_pkg::GNT_W];
  assign status = m_axis_tdata[pid_alloc_pkg::GNT_W +: pid_alloc_pkg::ST_W];

  // a stalled result beat holds
  `PID_ALLOC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

  // any failure reports id zero
  `PID_ALLOC_ASSERT_SAME(a_fail_zero, clk_i, rst_ni, m_axis_tvalid && (status != pid_alloc_pkg::ST_OK), grant == '0, "nonzero id with failure status")

  // one request in flight: ready drops after an accepted beat
  `PID_ALLOC_ASSERT_NEXT(a_one_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")

endmodule

bind per_context_lowest_free_id_allocator pid_alloc_chk u_pid_alloc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// ID allocator testbench
// A directed table and random phases. Each phase uses different sender and
// receiver idling. Each result beat is checked against a typed row's values
// or else a per-context predictor of fresh counters and returned-ID pools.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pid_alloc_pkg::*;

  localparam int CONTEXTS       = 64;
  localparam int HEAP_DEPTH     = 64;
  localparam int ID_BITS        = 16;
  localparam logic [ID_BITS-1:0] ID_MAX = '1;
  localparam logic [ACT_W-1:0] ACT_UNDEF = 2'd3;

  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [GNT_W-1:0] grant;
    logic [ST_W-1:0]  status;
  } id_result_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_FILL} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [ACT_W-1:0] act;
    logic [CTX_W-1:0] ctx;
    logic [FID_W-1:0] fid;
    logic             typed;  // expected values below are used as they stand
    logic [GNT_W-1:0] grant;
    logic [ST_W-1:0]  status;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_REQ,     ACT_ALLOC, 7'd0,   16'h0000, 1'b1, 16'd1,    ST_OK},
    '{ROW_REQ,     ACT_ALLOC, 7'd64,  16'h0000, 1'b1, 16'd0,    ST_BAD_CTX},
    '{ROW_REQ,     ACT_FREE,  7'd127, 16'hFFFF, 1'b1, 16'd0,    ST_BAD_CTX},
    '{ROW_REQ,     ACT_RESET, 7'd100, 16'h0000, 1'b1, 16'd0,    ST_BAD_CTX},
    '{ROW_REQ,     ACT_UNDEF, 7'd127, 16'hFFFF, 1'b1, 16'd0,    ST_BAD_CTX},
    '{ROW_REQ,     ACT_UNDEF, 7'd5,   16'h0000, 1'b1, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_FREE,  7'd0,   16'hFFFF, 1'b1, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_FREE,  7'd0,   16'h0000, 1'b1, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_FREE,  7'd0,   16'h0000, 1'b1, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_ALLOC, 7'd0,   16'h0000, 1'b1, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_ALLOC, 7'd0,   16'h0000, 1'b1, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_ALLOC, 7'd0,   16'h0000, 1'b1, 16'hFFFF, ST_OK},
    '{ROW_REQ,     ACT_ALLOC, 7'd0,   16'h0000, 1'b1, 16'd2,    ST_OK},
    '{ROW_REQ,     ACT_RESET, 7'd0,   16'h0000, 1'b1, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_ALLOC, 7'd0,   16'h0000, 1'b1, 16'd1,    ST_OK},
    '{ROW_FILL,    ACT_FREE,  7'd1,   16'h0000, 1'b0, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_FREE,  7'd1,   16'h0007, 1'b1, 16'd0,    ST_FULL},
    '{ROW_REQ,     ACT_ALLOC, 7'd1,   16'h0000, 1'b0, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_FREE,  7'd1,   16'hFFFF, 1'b0, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_ALLOC, 7'd63,  16'h0000, 1'b1, 16'd1,    ST_OK},
    '{ROW_REQ,     ACT_FREE,  7'd63,  16'h0005, 1'b1, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_ALLOC, 7'd63,  16'h0000, 1'b1, 16'd5,    ST_OK},
    '{ROW_REQ,     ACT_ALLOC, 7'd63,  16'h0000, 1'b1, 16'd2,    ST_OK},
    '{ROW_REQ,     ACT_RESET, 7'd63,  16'h0000, 1'b1, 16'd0,    ST_OK},
    '{ROW_REQ,     ACT_ALLOC, 7'd63,  16'h0000, 1'b1, 16'd1,    ST_OK}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // predictor state
  logic [ID_BITS-1:0] fresh_count [CONTEXTS];
  logic [ID_BITS-1:0] returned_ids [CONTEXTS][$];
  id_result_t         pending_results [$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  tx_idle_pct    = 0;
  int  rx_stall_pct   = 0;
  bit  hold_off_req   = 1'b0;

  per_context_lowest_free_id_allocator #(
    .CONTEXTS   (CONTEXTS),
    .HEAP_DEPTH (HEAP_DEPTH),
    .ID_BITS    (ID_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Only the minimum of a pool matters, so the pool is kept unordered.
  function automatic id_result_t predict_grant(input logic [ACT_W-1:0] act,
                                               input logic [CTX_W-1:0] ctx,
                                               input logic [FID_W-1:0] fid);
    id_result_t res;
    int         slot;
    int         low_idx;
    res.grant  = '0;
    res.status = ST_OK;
    slot       = int'(ctx);
    if (slot >= CONTEXTS) begin
      res.status = ST_BAD_CTX;
    end else begin
      case (act)
        ACT_ALLOC: begin
          if (returned_ids[slot].size() > 0) begin
            low_idx = 0;
            for (int i = 1; i < returned_ids[slot].size(); i++) begin
              if (returned_ids[slot][i] < returned_ids[slot][low_idx]) low_idx = i;
            end
            res.grant = returned_ids[slot][low_idx];
            returned_ids[slot].delete(low_idx);
          end else if (fresh_count[slot] == ID_MAX) begin
            res.status = ST_EXHAUSTED;
          end else begin
            fresh_count[slot] = fresh_count[slot] + 1'b1;
            res.grant         = fresh_count[slot];
          end
        end
        ACT_FREE: begin
          if (returned_ids[slot].size() >= HEAP_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            returned_ids[slot].push_back(fid[ID_BITS-1:0]);
          end
        end
        ACT_RESET: begin
          fresh_count[slot] = '0;
          returned_ids[slot].delete();
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  function automatic void note_mismatch(input string msg);
    if (mismatch_count < REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [CTX_W-1:0] ctx,
                              input logic [FID_W-1:0] fid, input logic typed,
                              input logic [GNT_W-1:0] grant, input logic [ST_W-1:0] status);
    id_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-FID_LSB-FID_W){1'b0}}, fid, ctx, act};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_grant(act, ctx, fid);
    if (typed) begin
      predicted.grant  = grant;
      predicted.status = status;
    end
    pending_results.push_back(predicted);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int free_pct);
    logic [ACT_W-1:0] act;
    logic [CTX_W-1:0] ctx;
    logic [FID_W-1:0] fid;
    int               roll;
    roll = $urandom_range(99);
    if (roll < free_pct)  act = ACT_FREE;
    else if (roll < 95)   act = ACT_ALLOC;
    else if (roll < 97)   act = ACT_RESET;
    else                  act = ACT_UNDEF;
    roll = $urandom_range(99);
    // two hot contexts so pools grow deep and sometimes fill up
    if (roll < 70)        ctx = CTX_W'($urandom_range(1));
    else if (roll < 92)   ctx = CTX_W'($urandom_range(CONTEXTS-1));
    else                  ctx = CTX_W'($urandom_range(127, CONTEXTS));
    // narrow IDs give duplicates, wide ones toggle every bit
    fid = ($urandom_range(1) == 1) ? FID_W'($urandom_range(15)) : FID_W'($urandom);
    send_request(act, ctx, fid, 1'b0, '0, ST_OK);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // result beat checker
  always @(posedge clk_i) begin
    id_result_t want;
    logic [GNT_W-1:0] got_grant;
    logic [ST_W-1:0]  got_status;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_grant  = m_axis_tdata[GNT_W-1:0];
      got_status = m_axis_tdata[GNT_W +: ST_W];
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected beat grant %h status %0d", got_grant, got_status));
      end else begin
        want = pending_results.pop_front();
        if (got_grant !== want.grant || got_status !== want.status) begin
          note_mismatch($sformatf("grant exp %h got %h, status exp %0d got %0d",
                                  want.grant, got_grant, want.status, got_status));
        end
      end
    end
  end

  // no beat on either side for too long ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    stim_row_t row;
    int        free_pct;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    foreach (fresh_count[c]) fresh_count[c] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED[r];
      case (row.kind)
        ROW_FILL: begin
          while (returned_ids[row.ctx].size() < HEAP_DEPTH) begin
            send_request(ACT_FREE, row.ctx, FID_W'($urandom), 1'b0, '0, ST_OK);
          end
        end
        default: begin
          send_request(row.act, row.ctx, row.fid, row.typed, row.grant, row.status);
        end
      endcase
    end
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  free_pct = 80; end
        1: begin tx_idle_pct = 72; rx_stall_pct = 0;  free_pct = 20; end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 72; free_pct = 50; end
        3: begin tx_idle_pct = 30; rx_stall_pct = 30; free_pct = 45; end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          free_pct     = 60;
          hold_off_req = 1'b1;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) send_random(free_pct);
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/pid_alloc_pkg.sv
rtl/core/pid_alloc_ctx_mem.sv
rtl/core/pid_alloc_heap_mem.sv
rtl/core/pid_alloc_heap_eng.sv
rtl/core/per_context_lowest_free_id_allocator.sv
rtl/core/pid_alloc_chk.sv
test/testbench.sv
